// File: hdl/snrp_pkg.sv
// Shared constants and types for the incoming-text notice parser.
// Used by snrp_front, snrp_cmd_fifo, snrp_emitter and the top level.
package snrp_pkg;

    localparam int NUMBER_CHARS   = 13;   // captured sender number length
    localparam int PREFIX_CHARS   = 3;    // country prefix dropped on output
    localparam int BODY_COUNT_MAX = 127;  // body byte counter saturation
    localparam int OUT_CHARS      = 10;   // number characters per completion
    localparam int CODE_LEN       = 5;    // bytes in the release word
    localparam int MIN_BODY       = 6;    // shortest body that can release

    localparam int NUM_IDX_W  = $clog2(NUMBER_CHARS);
    localparam int NUM_CNT_W  = $clog2(NUMBER_CHARS + 1);
    localparam int BODY_CNT_W = $clog2(BODY_COUNT_MAX + 1);
    localparam int OUT_IDX_W  = $clog2(OUT_CHARS);
    localparam int CODE_W     = 8 * CODE_LEN;

    localparam logic [7:0] QUOTE_BYTE = 8'h22;
    localparam logic [7:0] LF_BYTE    = 8'h0A;

    localparam logic [CODE_W-1:0] RELEASE_RESET = 40'h3C52454C3E;

    // register file
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 64;
    localparam logic [0:0] REG_RELEASE_CODE = 1'b0;

    // one completed notice handed from the parser to the emitter
    typedef struct packed {
        logic [OUT_CHARS-1:0][7:0] chars;
        logic                      ok;
    } emit_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

endpackage

// File: hdl/snrp_front.sv
// Byte parser: tracks notice phase, captures the sender number, checks the body.
// Depends on snrp_pkg; pushes one emit_cmd_t per completed notice.
module snrp_front
    import snrp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        rx_byte,
    input  logic [CODE_W-1:0] release_code,
    output logic              push,
    output emit_cmd_t         cmd
);

    localparam logic [1:0] PH_WAIT_QUOTE = 2'd0;
    localparam logic [1:0] PH_NUMBER     = 2'd1;
    localparam logic [1:0] PH_WAIT_LF    = 2'd2;
    localparam logic [1:0] PH_BODY       = 2'd3;

    logic [1:0]            phase_reg, phase_next;
    logic [NUM_CNT_W-1:0]  number_count_reg, number_count_next;
    logic [BODY_CNT_W-1:0] body_count_reg, body_count_next;
    logic                  code_match_reg, code_match_next;
    logic [7:0]            number_store_reg [NUMBER_CHARS];
    logic                  store_we;
    logic [7:0]            code_byte;

    always_comb
    begin
        unique case (body_count_reg[2:0])
            3'd0:    code_byte = release_code[39:32];
            3'd1:    code_byte = release_code[31:24];
            3'd2:    code_byte = release_code[23:16];
            3'd3:    code_byte = release_code[15:8];
            3'd4:    code_byte = release_code[7:0];
            default: code_byte = 8'h00;
        endcase
    end

    always_comb
    begin
        phase_next        = phase_reg;
        number_count_next = number_count_reg;
        body_count_next   = body_count_reg;
        code_match_next   = code_match_reg;
        store_we          = 1'b0;
        push              = 1'b0;
        if (accept)
        begin
            unique case (phase_reg)
                PH_WAIT_QUOTE:
                begin
                    if (rx_byte == QUOTE_BYTE)
                    begin
                        phase_next        = PH_NUMBER;
                        number_count_next = '0;
                    end
                end
                PH_NUMBER:
                begin
                    if (number_count_reg < NUM_CNT_W'(NUMBER_CHARS))
                    begin
                        store_we          = 1'b1;
                        number_count_next = number_count_reg + 1'b1;
                    end
                    else
                    begin
                        // byte after the number is dropped unseen
                        phase_next = PH_WAIT_LF;
                    end
                end
                PH_WAIT_LF:
                begin
                    if (rx_byte == LF_BYTE)
                    begin
                        phase_next      = PH_BODY;
                        body_count_next = '0;
                        code_match_next = 1'b1;
                    end
                end
                PH_BODY:
                begin
                    if (rx_byte == LF_BYTE)
                    begin
                        push              = 1'b1;
                        phase_next        = PH_WAIT_QUOTE;
                        number_count_next = '0;
                        body_count_next   = '0;
                        code_match_next   = 1'b1;
                    end
                    else if (body_count_reg < BODY_CNT_W'(BODY_COUNT_MAX))
                    begin
                        if (body_count_reg < BODY_CNT_W'(CODE_LEN) && rx_byte != code_byte)
                            code_match_next = 1'b0;
                        body_count_next = body_count_reg + 1'b1;
                    end
                end
                default:
                begin
                    phase_next = PH_WAIT_QUOTE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_WAIT_QUOTE;
            number_count_reg <= '0;
            body_count_reg   <= '0;
            code_match_reg   <= 1'b1;
        end
        else
        begin
            phase_reg        <= phase_next;
            number_count_reg <= number_count_next;
            body_count_reg   <= body_count_next;
            code_match_reg   <= code_match_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
            number_store_reg[number_count_reg[NUM_IDX_W-1:0]] <= rx_byte;
    end

    // drop the prefix; positions beyond the number read as zero
    always_comb
    begin
        for (int k = 0; k < OUT_CHARS; k++)
        begin
            if (PREFIX_CHARS + k < NUMBER_CHARS)
                cmd.chars[k] = number_store_reg[NUM_IDX_W'((PREFIX_CHARS + k < NUMBER_CHARS)
                                                ? PREFIX_CHARS + k : 0)];
            else
                cmd.chars[k] = 8'h00;
        end
        cmd.ok = code_match_reg && (body_count_reg >= BODY_CNT_W'(MIN_BODY));
    end

endmodule

// File: hdl/snrp_cmd_fifo.sv
// Two-entry queue of completed notices between parser and emitter.
// Depends on snrp_pkg for emit_cmd_t and fifo_status_t.
module snrp_cmd_fifo
    import snrp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  emit_cmd_t    wr_data,
    input  logic         pop,
    output emit_cmd_t    rd_data,
    output fifo_status_t status
);

    emit_cmd_t  entry_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= wr_data;
    end

    assign rd_data      = entry_reg[rd_ptr_reg];
    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);

endmodule

// File: hdl/snrp_emitter.sv
// Result sequencer: plays out the ten number characters of one notice.
// Depends on snrp_pkg; takes commands from snrp_cmd_fifo.
module snrp_emitter
    import snrp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  emit_cmd_t    cmd,
    input  fifo_status_t status,
    output logic         pop,
    output logic         out_valid,
    input  logic         out_stall,
    output logic [7:0]   number_char,
    output logic         release_ok,
    output logic         last_char
);

    emit_cmd_t            cmd_reg;
    logic                 busy_reg;
    logic [OUT_IDX_W-1:0] idx_reg;
    logic                 out_accept;
    logic                 last;

    assign last       = (idx_reg == OUT_IDX_W'(OUT_CHARS - 1));
    assign out_accept = busy_reg && !out_stall;
    // next notice loads in the cycle the last character leaves
    assign pop        = !status.empty && (!busy_reg || (out_accept && last));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (pop)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end
        else if (out_accept)
        begin
            if (last)
                busy_reg <= 1'b0;
            else
                idx_reg <= idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            cmd_reg <= cmd;
    end

    assign out_valid   = busy_reg;
    assign number_char = cmd_reg.chars[idx_reg];
    assign release_ok  = cmd_reg.ok;
    assign last_char   = last;

endmodule

// File: hdl/sms_notice_release_parser_unit.sv
// Top level of the incoming-text notice parser with release-word check.
// Depends on snrp_pkg, snrp_front, snrp_cmd_fifo and snrp_emitter.
//
//   channel | signals                                  | moves
//   --------+------------------------------------------+---------------------------
//   in      | in_valid, in_stall, rx_byte              | one serial byte
//   out     | out_valid, out_stall, number_char,       | one number character
//           | release_ok, last_char                    |
//   cfg     | psel, penable, pwrite, paddr, pwdata,    | release_code at 0x0
//           | prdata, pready                           |
//
// One byte is taken per cycle while in_stall is low; the parser finishes each
// byte in that cycle. A closing line feed queues a notice; the emitter sends
// its ten characters, one per out transaction. The two-entry notice queue
// sets in_stall when full. Reset clears control state; no clearing pass.
module sms_notice_release_parser_unit
    import snrp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [7:0]            rx_byte,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [7:0]            number_char,
    output logic                  release_ok,
    output logic                  last_char,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [CODE_W-1:0] release_code_reg;
    logic              cfg_sel;
    logic              in_accept;
    logic              push;
    logic              pop;
    emit_cmd_t         front_cmd;
    emit_cmd_t         fifo_cmd;
    fifo_status_t      fifo_status;

    assign pready  = 1'b1;
    assign cfg_sel = (paddr[CFG_ADDR_W-1:3] == {(CFG_ADDR_W-3){REG_RELEASE_CODE}});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            release_code_reg <= RELEASE_RESET;
        else if (psel && penable && pwrite && pready && cfg_sel)
            release_code_reg <= pwdata[CODE_W-1:0];
    end

    assign prdata    = cfg_sel ? {{(CFG_DATA_W-CODE_W){1'b0}}, release_code_reg} : '0;
    assign in_stall  = fifo_status.full;
    assign in_accept = in_valid && !in_stall;

    snrp_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (in_accept),
        .rx_byte      (rx_byte),
        .release_code (release_code_reg),
        .push         (push),
        .cmd          (front_cmd)
    );

    snrp_cmd_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (front_cmd),
        .pop     (pop),
        .rd_data (fifo_cmd),
        .status  (fifo_status)
    );

    snrp_emitter u_emitter (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (fifo_cmd),
        .status      (fifo_status),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .number_char (number_char),
        .release_ok  (release_ok),
        .last_char   (last_char)
    );

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !fifo_status.full)
        else $error("notice pushed into full queue");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !fifo_status.empty)
        else $error("notice popped from empty queue");

    a_burst_starts_first: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !$past(out_valid) |-> !last_char)
        else $error("burst started on last character");

    a_flag_steady_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && $past(out_valid && !last_char) |-> release_ok == $past(release_ok))
        else $error("release flag changed within a burst");

endmodule

// File: tb/sv/snrp_checker.sv
// Checker for sms_notice_release_parser_unit: watches the in, out and cfg channels,
// predicts and compares each notice's characters, release_ok and last_char; checks reads.
// Depends on snrp_pkg.
module snrp_checker
    import snrp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic [7:0]            rx_byte,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic [7:0]            number_char,
    input  logic                  release_ok,
    input  logic                  last_char,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    input  logic [CFG_DATA_W-1:0] prdata,
    input  logic                  pready,
    output int                    fail_count,
    output int                    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_ADDR_W-1:0] CODE_ADDR = CFG_ADDR_W'(8 * REG_RELEASE_CODE);

    typedef enum logic [1:0] {SEEK_QUOTE, TAKE_NUMBER, SEEK_LF, TAKE_BODY} phase_e;

    typedef struct packed {
        logic [7:0] ch;
        logic       ok;
        logic       last;
    } char_due_t;

    char_due_t         chars_due[$];
    phase_e            phase;
    int                num_cnt;
    logic [7:0]        num_store[16];
    int                body_len;
    logic              body_match;
    logic [CODE_W-1:0] code_reg;

    initial fail_count = 0;
    initial pending = 0;

    task automatic report_mismatch(input string msg);
        $display("[%0t] snrp check: %s", $realtime, msg);
        fail_count++;
    endtask

    // one accepted serial byte; a closing line feed queues ten characters
    task automatic absorb_byte(input logic [7:0] b);
        logic      ok;
        int        pos;
        char_due_t e;
        case (phase)
            SEEK_QUOTE:
                if (b == QUOTE_BYTE)
                begin
                    phase   = TAKE_NUMBER;
                    num_cnt = 0;
                end
            TAKE_NUMBER:
                if (num_cnt < NUMBER_CHARS)
                begin
                    num_store[num_cnt] = b;
                    num_cnt++;
                end
                else
                    phase = SEEK_LF;   // byte after the number is dropped unseen
            SEEK_LF:
                if (b == LF_BYTE)
                begin
                    phase      = TAKE_BODY;
                    body_len   = 0;
                    body_match = 1'b1;
                end
            default:
                if (b == LF_BYTE)
                begin
                    ok = body_match && (body_len >= MIN_BODY);
                    for (int k = 0; k < OUT_CHARS; k++)
                    begin
                        pos    = PREFIX_CHARS + k;
                        e.ch   = (pos < NUMBER_CHARS) ? num_store[pos] : 8'h00;
                        e.ok   = ok;
                        e.last = (k == OUT_CHARS - 1);
                        chars_due.push_back(e);
                    end
                    phase      = SEEK_QUOTE;
                    num_cnt    = 0;
                    body_len   = 0;
                    body_match = 1'b1;
                end
                else if (body_len < BODY_COUNT_MAX)
                begin
                    if (body_len < CODE_LEN &&
                        b != code_reg[8*(CODE_LEN-1-body_len) +: 8])
                        body_match = 1'b0;
                    body_len++;
                end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chars_due.delete();
            phase      = SEEK_QUOTE;
            num_cnt    = 0;
            body_len   = 0;
            body_match = 1'b1;
            code_reg   = RELEASE_RESET;
            for (int i = 0; i < 16; i++)
                num_store[i] = 8'h00;
        end
        else
        begin
            if (psel && penable && pready && paddr == CODE_ADDR)
            begin
                if (pwrite)
                    code_reg = pwdata[CODE_W-1:0];
                else if (prdata !== CFG_DATA_W'(code_reg))
                    report_mismatch($sformatf("release_code read %h, want %h",
                                              prdata, code_reg));
            end
            if (in_valid && !in_stall)
                absorb_byte(rx_byte);
            if (out_valid && !out_stall)
            begin
                if (chars_due.size() == 0)
                    report_mismatch($sformatf("unexpected character %h", number_char));
                else
                begin
                    char_due_t e;
                    e = chars_due.pop_front();
                    if (number_char !== e.ch)
                        report_mismatch($sformatf("number_char %h, want %h",
                                                  number_char, e.ch));
                    if (release_ok !== e.ok)
                        report_mismatch($sformatf("release_ok %b, want %b",
                                                  release_ok, e.ok));
                    if (last_char !== e.last)
                        report_mismatch($sformatf("last_char %b, want %b",
                                                  last_char, e.last));
                end
            end
        end
        pending = chars_due.size();
    end

endmodule

// File: tb/sv/tb_sms_notice_release_parser_unit.sv
// Testbench top for sms_notice_release_parser_unit: drives notice byte streams,
// release-word writes and output stalls; snrp_checker does the comparing.
// Depends on snrp_pkg, snrp_checker and the unit itself.
module tb_sms_notice_release_parser_unit;
    import snrp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int          DRAIN_CYCLES = 20;
    localparam logic [CFG_ADDR_W-1:0] CODE_ADDR = CFG_ADDR_W'(8 * REG_RELEASE_CODE);

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [7:0]            rx_byte = 8'h00;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [7:0]            number_char;
    logic                  release_ok;
    logic                  last_char;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    int                    fail_count;
    int                    pending;
    int unsigned           cycle_count = 0;

    logic [7:0]            frame[$];
    logic [CODE_W-1:0]     code_word = RELEASE_RESET;
    bit                    in_quiet = 1'b1;
    bit                    out_quiet = 1'b1;
    int                    stall_hold = 0;
    int                    stall_roll;

    // number with the byte extremes, a quote and line feeds inside it
    logic [7:0] odd_number[NUMBER_CHARS] = '{8'h00, 8'hFF, 8'h0A, 8'h22, 8'h01, 8'h80,
                                             8'h7F, 8'hFE, 8'h55, 8'hAA, 8'h0A, 8'h30,
                                             8'h39};

    sms_notice_release_parser_unit uut (.*);

    snrp_checker chk (.*);

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("sms_notice_release_parser_unit: mismatch");
            $finish;
        end
    end

    // receiver stalls: bursts of random length, none started while out_quiet
    always @(posedge clk)
    begin
        if (stall_hold > 0)
            stall_hold <= stall_hold - 1;
        else if (out_quiet)
            out_stall <= 1'b0;
        else
        begin
            stall_roll = $urandom_range(0, 99);
            if (stall_roll < 60)
            begin
                out_stall  <= 1'b0;
                stall_hold <= $urandom_range(0, 5);
            end
            else if (stall_roll < 95)
            begin
                out_stall  <= 1'b1;
                stall_hold <= $urandom_range(0, 3);
            end
            else
            begin
                out_stall  <= 1'b1;
                stall_hold <= $urandom_range(10, 40);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (in_quiet || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    function automatic logic [7:0] rand_byte_not(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] v;
        do
            v = 8'($urandom_range(0, 255));
        while (v == a || v == b);
        return v;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int  gap;
        bit  taken;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        forever
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
            if (taken)
                break;
        end
    endtask

    // in_valid stays up after the last byte until the next byte or settle()
    task automatic send_frame();
        foreach (frame[i])
            send_byte(frame[i]);
        frame.delete();
    endtask

    // appends one notice: noise, quote, number, skipped byte, filler, LF, body, LF
    task automatic add_notice(input int body_len, input int bad_pos, input int lead,
                              input bit odd);
        logic [7:0] cb;
        repeat (lead)
            frame.push_back(rand_byte_not(QUOTE_BYTE, QUOTE_BYTE));
        frame.push_back(QUOTE_BYTE);
        for (int i = 0; i < NUMBER_CHARS; i++)
            frame.push_back(odd ? odd_number[i] : 8'($urandom_range(0, 255)));
        if (odd)
            frame.push_back(LF_BYTE);   // skipped byte must not open the body
        else
        begin
            frame.push_back(8'($urandom_range(0, 255)));
            repeat ($urandom_range(0, 2))
                frame.push_back(rand_byte_not(LF_BYTE, LF_BYTE));
        end
        frame.push_back(LF_BYTE);
        for (int i = 0; i < body_len; i++)
        begin
            if (i < CODE_LEN)
            begin
                cb = code_word[8*(CODE_LEN-1-i) +: 8];
                if (i == bad_pos || cb == LF_BYTE)
                    cb = rand_byte_not(cb, LF_BYTE);
                frame.push_back(cb);
            end
            else
                frame.push_back(rand_byte_not(LF_BYTE, LF_BYTE));
        end
        frame.push_back(LF_BYTE);
    endtask

    task automatic cfg_access(input bit wr, input logic [CODE_W-1:0] v);
        bit done;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= CODE_ADDR;
        pwdata  <= {24'($urandom), v};
        @(posedge clk);
        penable <= 1'b1;
        forever
        begin
            @(negedge clk);
            done = pready;
            @(posedge clk);
            if (done)
                break;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        if (wr)
            code_word = v;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_code(input logic [CODE_W-1:0] v);
        settle();
        cfg_access(1'b1, v);
        cfg_access(1'b0, '0);
    endtask

    task automatic random_phase(input int byte_budget);
        int sent;
        int r;
        int len;
        sent = 0;
        while (sent < byte_budget)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                in_quiet  = $urandom_range(0, 2) == 0;
                out_quiet = $urandom_range(0, 2) == 0;
            end
            r = $urandom_range(0, 99);
            if (r < 80)
            begin
                r = $urandom_range(0, 99);
                if (r < 70)
                    len = $urandom_range(0, 12);
                else if (r < 95)
                    len = $urandom_range(13, 30);
                else
                    len = $urandom_range(120, 140);
                add_notice(len, ($urandom_range(0, 1) == 0) ? -1 : $urandom_range(0, 5),
                           $urandom_range(0, 3), 1'b0);
            end
            else
                repeat ($urandom_range(3, 15))
                    frame.push_back(8'($urandom_range(0, 255)));
            sent += frame.size();
            send_frame();
        end
    endtask

    function automatic logic [CODE_W-1:0] random_code();
        logic [CODE_W-1:0] v;
        if ($urandom_range(0, 1) == 0)
            v = {8'($urandom), 32'($urandom)};
        else
            for (int i = 0; i < CODE_LEN; i++)
                v[8*i +: 8] = 8'($urandom_range(8'h21, 8'h7E));
        return v;
    endfunction

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        cfg_access(1'b0, '0);          // reset value of the release word
        add_notice(6, -1, 2, 1'b1);    // exact match, shortest body that releases
        add_notice(5, -1, 0, 1'b0);    // word only: too short
        add_notice(0, -1, 1, 1'b0);    // empty body
        add_notice(8, 4, 0, 1'b0);     // last word byte wrong
        add_notice(135, -1, 0, 1'b0);  // body counter saturates
        send_frame();

        set_code({CODE_W{1'b1}});
        out_quiet = 1'b0;
        add_notice(6, -1, 0, 1'b0);
        add_notice(7, 0, 0, 1'b0);
        send_frame();
        in_quiet = 1'b0;
        random_phase(20);

        set_code('0);
        add_notice(6, -1, 0, 1'b1);
        send_frame();
        random_phase(10);

        repeat (2)
        begin
            set_code(random_code());
            random_phase(10);
        end

        settle();
        if (fail_count == 0)
            $display("sms_notice_release_parser_unit: match");
        else
            $display("sms_notice_release_parser_unit: mismatch");
        $finish;
    end

endmodule
